/* sv/odo_pkg.sv */
package odo_pkg;

  // Field and register widths
  localparam int RAW_W      = 16;
  localparam int CPR_W      = 16;
  localparam int SCALE_W    = 32;
  localparam int HR_W       = 16;
  localparam int ROT_W      = 24;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_SHIFT = 16;

  // Datapath widths: wrapped delta, multiplier operand A, product register
  localparam int DELTA_W = RAW_W + 2;
  localparam int OPA_W   = WORD_W + 1;
  localparam int PROD_W  = OPA_W + ROT_W + 1;

  // Register reset values
  localparam logic [CPR_W-1:0]   CPR_RST   = CPR_W'(4096);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(100531);
  localparam logic [HR_W-1:0]    HR_RST    = HR_W'(1638);
  localparam logic [ROT_W-1:0]   ROT_RST   = ROT_W'(16384);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_PER_REV    = 2'd0,
    CFG_VELOCITY_SCALE    = 2'd1,
    CFG_HALF_RADIUS       = 2'd2,
    CFG_RADIUS_OVER_TRACK = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CPR_W-1:0]   counts_per_rev;
    logic [SCALE_W-1:0] velocity_scale;
    logic [HR_W-1:0]    half_radius;
    logic [ROT_W-1:0]   radius_over_track;
  } cfg_t;

  // Multiplier operand pair
  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_LEFT  = 3'd1,
    MUL_RIGHT = 3'd2,
    MUL_FWD   = 3'd3,
    MUL_YAW   = 3'd4
  } mul_sel_e;

  // Destination of the saturated product
  typedef enum logic [2:0] {
    WB_NONE       = 3'd0,
    WB_LEFT_RATE  = 3'd1,
    WB_RIGHT_RATE = 3'd2,
    WB_FWD        = 3'd3,
    WB_YAW        = 3'd4
  } wb_sel_e;

  // Program steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_DELTA      = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_LEFT   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_RIGHT  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_WB_RIGHT   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SUMS       = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_FWD    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_YAW    = 3'd6;
  localparam logic [STEP_W-1:0] STEP_WB_YAW     = 3'd7;

  // One control word of the microprogram
  typedef struct packed {
    logic              delta_en;
    logic              pos_en;
    logic              sums_en;
    mul_sel_e          mul_sel;
    wb_sel_e           wb_sel;
    logic              jump_unprimed;
    logic [STEP_W-1:0] jump_to;
    logic              last;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    delta_en:      1'b0,
    pos_en:        1'b0,
    sums_en:       1'b0,
    mul_sel:       MUL_NONE,
    wb_sel:        WB_NONE,
    jump_unprimed: 1'b0,
    jump_to:       STEP_DELTA,
    last:          1'b0
  };

  // Microprogram ROM
  function automatic ctrl_t microcode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = CTRL_NOP;
    case (step)
      STEP_DELTA: begin
        w.delta_en      = 1'b1;
        w.jump_unprimed = 1'b1;
        w.jump_to       = STEP_SUMS;
      end
      STEP_MUL_LEFT: begin
        w.pos_en  = 1'b1;
        w.mul_sel = MUL_LEFT;
      end
      STEP_MUL_RIGHT: begin
        w.mul_sel = MUL_RIGHT;
        w.wb_sel  = WB_LEFT_RATE;
      end
      STEP_WB_RIGHT: begin
        w.wb_sel = WB_RIGHT_RATE;
      end
      STEP_SUMS: begin
        w.sums_en = 1'b1;
      end
      STEP_MUL_FWD: begin
        w.mul_sel = MUL_FWD;
      end
      STEP_MUL_YAW: begin
        w.mul_sel = MUL_YAW;
        w.wb_sel  = WB_FWD;
      end
      STEP_WB_YAW: begin
        w.wb_sel = WB_YAW;
        w.last   = 1'b1;
      end
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

endpackage

/* sv/odo_if.sv */
// Input channel: raw encoder positions of one sample tick
interface odo_in_if;
  import odo_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] left_raw;
  logic [RAW_W-1:0] right_raw;

  modport source (output valid, output left_raw, output right_raw, input ready);
  modport sink   (input valid, input left_raw, input right_raw, output ready);
endinterface

// Output channel: odometry result word
interface odo_out_if;
  import odo_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] left_position;
  logic signed [WORD_W-1:0] right_position;
  logic signed [WORD_W-1:0] left_rate;
  logic signed [WORD_W-1:0] right_rate;
  logic signed [WORD_W-1:0] forward_velocity;
  logic signed [WORD_W-1:0] yaw_rate;
  logic                     valid_res;

  modport source (
    output valid, output left_position, output right_position, output left_rate,
    output right_rate, output forward_velocity, output yaw_rate, output valid_res,
    input ready
  );
  modport sink (
    input valid, input left_position, input right_position, input left_rate,
    input right_rate, input forward_velocity, input yaw_rate, input valid_res,
    output ready
  );
endinterface

/* sv/odo_seq.sv */
module odo_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          start_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  logic          primed_i,
  output odo_pkg::ctrl_t ctrl_o
);
  import odo_pkg::*;

  logic              running_q, running_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  ctrl_t             word;
  logic              stall;
  logic              advance;
  logic              accept;
  logic [STEP_W-1:0] next_step;

  // Fetch and issue; the last step waits while the output word is still held
  assign word    = microcode(step_q);
  assign stall   = word.last & out_valid_q & ~out_ready_i;
  assign advance = running_q & ~stall;
  assign ctrl_o  = advance ? word : CTRL_NOP;

  assign accept     = in_valid_i & ~running_q;
  assign in_ready_o = ~running_q;
  assign start_o    = accept;
  assign out_valid_o = out_valid_q;

  // Conditional jump on the unprimed flag, otherwise fall through
  assign next_step = (word.jump_unprimed && !primed_i) ? word.jump_to
                                                       : step_q + STEP_W'(1);

  always_comb begin
    running_d   = running_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      running_d = 1'b1;
      step_d    = STEP_DELTA;
    end else if (advance) begin
      step_d = next_step;
      if (word.last) begin
        running_d   = 1'b0;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      step_q      <= STEP_DELTA;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/odo_dp.sv */
module odo_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  odo_pkg::cfg_t                    cfg_i,
  input  logic                             start_i,
  input  logic [odo_pkg::RAW_W-1:0]        left_raw_i,
  input  logic [odo_pkg::RAW_W-1:0]        right_raw_i,
  input  odo_pkg::ctrl_t                   ctrl_i,
  output logic                             primed_o,
  output logic signed [odo_pkg::WORD_W-1:0] left_position_o,
  output logic signed [odo_pkg::WORD_W-1:0] right_position_o,
  output logic signed [odo_pkg::WORD_W-1:0] left_rate_o,
  output logic signed [odo_pkg::WORD_W-1:0] right_rate_o,
  output logic signed [odo_pkg::WORD_W-1:0] forward_velocity_o,
  output logic signed [odo_pkg::WORD_W-1:0] yaw_rate_o,
  output logic                             valid_res_o
);
  import odo_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_POS = PROD_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] ROUND_NEG = ROUND_POS - PROD_W'(1);
  localparam logic signed [WORD_W-1:0] WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

  // Shortest signed step modulo the encoder resolution
  function automatic logic signed [DELTA_W-1:0] wrap_delta(
    input logic [RAW_W-1:0] prev,
    input logic [RAW_W-1:0] cur,
    input logic [CPR_W-1:0] cpr
  );
    logic signed [DELTA_W-1:0] d;
    logic signed [DELTA_W-1:0] span;
    logic signed [DELTA_W-1:0] half;
    d    = $signed({2'b00, cur}) - $signed({2'b00, prev});
    span = $signed({{(DELTA_W-CPR_W){1'b0}}, cpr});
    half = $signed({{(DELTA_W-CPR_W+1){1'b0}}, cpr[CPR_W-1:1]});
    if (d > half) begin
      d = d - span;
    end else if (d < -half) begin
      d = d + span;
    end
    return d;
  endfunction

  // Clamp a product-wide value to a 32-bit word
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] x);
    logic in_range;
    in_range = (&x[PROD_W-1:WORD_W-1]) | ~(|x[PROD_W-1:WORD_W-1]);
    if (in_range) begin
      return x[WORD_W-1:0];
    end else begin
      return x[PROD_W-1] ? WORD_MIN : WORD_MAX;
    end
  endfunction

  logic [RAW_W-1:0]          left_cur_q, right_cur_q;
  logic [RAW_W-1:0]          left_prev_q, right_prev_q;
  logic                      primed_q;
  logic                      valid_q;
  logic signed [DELTA_W-1:0] left_delta_q, right_delta_q;
  logic signed [WORD_W-1:0]  left_pos_q, right_pos_q;
  logic signed [WORD_W-1:0]  left_vel_q, right_vel_q;
  logic signed [OPA_W-1:0]   sum_q, diff_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [WORD_W-1:0]  fwd_q;

  logic signed [OPA_W-1:0]          opa;
  logic [SCALE_W-1:0]               opb;
  logic signed [OPA_W+SCALE_W:0]    mul_full;
  logic signed [PROD_W-1:0]         biased;
  logic signed [PROD_W-1:0]         shifted;
  logic signed [WORD_W-1:0]         prod_sat;
  logic signed [WORD_W-1:0]         round_sat;

  logic signed [WORD_W-1:0] out_left_pos_q, out_right_pos_q;
  logic signed [WORD_W-1:0] out_left_rate_q, out_right_rate_q;
  logic signed [WORD_W-1:0] out_fwd_q, out_yaw_q;
  logic                     out_valid_res_q;

  assign primed_o = primed_q;

  // Shared multiplier operand select
  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_LEFT: begin
        opa = {{(OPA_W-DELTA_W){left_delta_q[DELTA_W-1]}}, left_delta_q};
        opb = cfg_i.velocity_scale;
      end
      MUL_RIGHT: begin
        opa = {{(OPA_W-DELTA_W){right_delta_q[DELTA_W-1]}}, right_delta_q};
        opb = cfg_i.velocity_scale;
      end
      MUL_FWD: begin
        opa = sum_q;
        opb = {{(SCALE_W-HR_W){1'b0}}, cfg_i.half_radius};
      end
      MUL_YAW: begin
        opa = diff_q;
        opb = {{(SCALE_W-ROT_W){1'b0}}, cfg_i.radius_over_track};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mul_full = opa * $signed({1'b0, opb});

  // Writeback: plain clamp for wheel rates, round half away then clamp for chassis
  assign prod_sat  = sat_word(prod_q);
  assign biased    = prod_q + (prod_q[PROD_W-1] ? ROUND_NEG : ROUND_POS);
  assign shifted   = biased >>> FRAC_SHIFT;
  assign round_sat = sat_word(shifted);

  // Odometry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_prev_q  <= '0;
      right_prev_q <= '0;
      primed_q     <= 1'b0;
      left_pos_q   <= '0;
      right_pos_q  <= '0;
      left_vel_q   <= '0;
      right_vel_q  <= '0;
    end else begin
      if (ctrl_i.delta_en) begin
        left_prev_q  <= left_cur_q;
        right_prev_q <= right_cur_q;
        primed_q     <= 1'b1;
      end
      if (ctrl_i.pos_en) begin
        left_pos_q  <= left_pos_q + WORD_W'(left_delta_q);
        right_pos_q <= right_pos_q + WORD_W'(right_delta_q);
      end
      if (ctrl_i.wb_sel == WB_LEFT_RATE) begin
        left_vel_q <= prod_sat;
      end
      if (ctrl_i.wb_sel == WB_RIGHT_RATE) begin
        right_vel_q <= prod_sat;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      left_cur_q  <= left_raw_i;
      right_cur_q <= right_raw_i;
    end
    if (ctrl_i.delta_en) begin
      left_delta_q  <= wrap_delta(left_prev_q, left_cur_q, cfg_i.counts_per_rev);
      right_delta_q <= wrap_delta(right_prev_q, right_cur_q, cfg_i.counts_per_rev);
      valid_q       <= primed_q;
    end
    if (ctrl_i.sums_en) begin
      sum_q  <= {left_vel_q[WORD_W-1], left_vel_q} + {right_vel_q[WORD_W-1], right_vel_q};
      diff_q <= {right_vel_q[WORD_W-1], right_vel_q} - {left_vel_q[WORD_W-1], left_vel_q};
    end
    if (ctrl_i.mul_sel != MUL_NONE) begin
      prod_q <= mul_full[PROD_W-1:0];
    end
    if (ctrl_i.wb_sel == WB_FWD) begin
      fwd_q <= round_sat;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.last) begin
      out_left_pos_q   <= left_pos_q;
      out_right_pos_q  <= right_pos_q;
      out_left_rate_q  <= left_vel_q;
      out_right_rate_q <= right_vel_q;
      out_fwd_q        <= fwd_q;
      out_valid_res_q  <= valid_q;
    end
    if (ctrl_i.wb_sel == WB_YAW) begin
      out_yaw_q <= round_sat;
    end
  end

  assign left_position_o    = out_left_pos_q;
  assign right_position_o   = out_right_pos_q;
  assign left_rate_o        = out_left_rate_q;
  assign right_rate_o       = out_right_rate_q;
  assign forward_velocity_o = out_fwd_q;
  assign yaw_rate_o         = out_yaw_q;
  assign valid_res_o        = out_valid_res_q;

endmodule

/* sv/differential_wheel_odometry.sv */
// Each accepted sample word runs the 8-step microprogram, which takes both
//   wheel rates and both chassis products through one shared multiplier; the
//   first sample after reset only primes the block and skips the wheel position
//   and rate steps. A new sample word is accepted only while no program runs;
//   the last step waits while the previous result word is still held.
// Reset: asynchronous, active low; clears the odometry state and loads the
//   register defaults. The block is ready in the first cycle after reset.
module differential_wheel_odometry (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [odo_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  odo_in_if.sink                            in_ch,
  odo_out_if.source                         out_ch
);
  import odo_pkg::*;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  logic  primed;
  logic  start;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counts_per_rev    <= CPR_RST;
      cfg_q.velocity_scale    <= SCALE_RST;
      cfg_q.half_radius       <= HR_RST;
      cfg_q.radius_over_track <= ROT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COUNTS_PER_REV:    cfg_q.counts_per_rev    <= cfg_data_i[CPR_W-1:0];
        CFG_VELOCITY_SCALE:    cfg_q.velocity_scale    <= cfg_data_i[SCALE_W-1:0];
        CFG_HALF_RADIUS:       cfg_q.half_radius       <= cfg_data_i[HR_W-1:0];
        CFG_RADIUS_OVER_TRACK: cfg_q.radius_over_track <= cfg_data_i[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // Step sequencer
  odo_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .start_o     (start),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .primed_i    (primed),
    .ctrl_o      (ctrl)
  );

  // Datapath
  odo_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .start_i            (start),
    .left_raw_i         (in_ch.left_raw),
    .right_raw_i        (in_ch.right_raw),
    .ctrl_i             (ctrl),
    .primed_o           (primed),
    .left_position_o    (out_ch.left_position),
    .right_position_o   (out_ch.right_position),
    .left_rate_o        (out_ch.left_rate),
    .right_rate_o       (out_ch.right_rate),
    .forward_velocity_o (out_ch.forward_velocity),
    .yaw_rate_o         (out_ch.yaw_rate),
    .valid_res_o        (out_ch.valid_res)
  );

  // The priming word reports the reset state
  a_prime_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.valid_res |->
      out_ch.left_position == '0 && out_ch.right_position == '0 &&
      out_ch.left_rate == '0 && out_ch.right_rate == '0)
    else $error("priming word carries nonzero state");

  // Equal wheel rates mean no yaw
  a_no_yaw_on_equal_rates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.left_rate == out_ch.right_rate |-> out_ch.yaw_rate == '0)
    else $error("yaw rate nonzero with equal wheel rates");

  // Opposite wheel rates mean no forward motion; sum taken one bit wider
  a_no_fwd_on_opposite_rates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid &&
      ({out_ch.left_rate[WORD_W-1], out_ch.left_rate} +
       {out_ch.right_rate[WORD_W-1], out_ch.right_rate}) == '0 |->
      out_ch.forward_velocity == '0)
    else $error("forward velocity nonzero with opposite wheel rates");

  // A new result only appears at the end of a program run
  a_result_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> !$past(in_ch.ready))
    else $error("result word raised while sequencer idle");

endmodule
